// ===== hw/rtl/bbpll_pkg.sv =====
// shared constants and codes for the bang-bang pll loop step
`default_nettype none

package bbpll_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_REF_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DCO_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN    = 3'd5;

    // detector codes
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    // saturation limits
    localparam logic signed [63:0] S64_MAX   = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] S64_MIN   = 64'sh8000_0000_0000_0000;
    localparam logic signed [23:0] INTEG_MAX = 24'sh7f_ffff;
    localparam logic signed [23:0] INTEG_MIN = 24'sh80_0000;
    localparam logic signed [42:0] CTRL_MAX  = 43'sh7f_ffff_ffff;
    localparam logic signed [42:0] CTRL_MIN  = 43'sh780_0000_0000;

endpackage

`default_nettype wire

// ===== hw/rtl/bbpll_mul.sv =====
// shared unsigned multiplier with registered product
`default_nettype none

module bbpll_mul (
    input  wire logic                         clk,
    input  wire logic [bbpll_pkg::MUL_W-1:0]  a,
    input  wire logic [bbpll_pkg::MUL_W-1:0]  b,
    output logic      [bbpll_pkg::PROD_W-1:0] prod
);

    logic [bbpll_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= bbpll_pkg::PROD_W'(a) * bbpll_pkg::PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bang_bang_pll_loop_step.sv =====
// top level: one reference cycle of a bang-bang digital pll per transfer
//
// channel   direction  handshake              payload
// in        sink       in_valid / in_ready    noise_fs, restart
// out       source     out_valid / out_ready  phase_err_fs, detector_sign, control_word,
//                                              reversal_count, square_sum
// cfg       sink       cfg_write              cfg_index, cfg_data
//
// the result is registered as the sequencer leaves its last step, and in_ready returns
// with it; the sequencer runs six products through the one 32x32 multiplier and three
// saturating adds through the phase accumulator, one per cycle
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register while the next item is taken, and a second result holds the sequencer
// in its last step until the output register is free
// rst_n clears all loop state and loads the configuration defaults; no clearing pass
`default_nettype none

module bang_bang_pll_loop_step #(
    parameter int LOOP_DELAY  = 0,
    parameter int PHASE_WIDTH = 48
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [31:0]                 noise_fs,
    input  wire logic                               restart,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [47:0]                      phase_err_fs,
    output logic        [1:0]                       detector_sign,
    output logic signed [39:0]                      control_word,
    output logic        [31:0]                      reversal_count,
    output logic        [63:0]                      square_sum,
    input  wire logic                               cfg_write,
    input  wire logic [bbpll_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bbpll_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int HIST_D = LOOP_DELAY + 1;
    localparam logic signed [63:0] PH_MAX =
        signed'((64'd1 << (PHASE_WIDTH - 1)) - 64'd1);
    localparam logic signed [63:0] PH_MIN = ~PH_MAX;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_MLO  = 13'b0000000000010,
        ST_MHI  = 13'b0000000000100,
        ST_PER  = 13'b0000000001000,
        ST_DLO  = 13'b0000000010000,
        ST_DHI  = 13'b0000000100000,
        ST_SUM  = 13'b0000001000000,
        ST_SUBP = 13'b0000010000000,
        ST_NOIS = 13'b0000100000000,
        ST_ERR  = 13'b0001000000000,
        ST_SQ   = 13'b0010000000000,
        ST_CTL  = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [31:0] ref_period_reg;
    logic [31:0] free_period_reg;
    logic [9:0]  divide_reg;
    logic [31:0] dco_gain_reg;
    logic [16:0] prop_gain_reg;
    logic [16:0] int_gain_reg;

    // loop state
    logic signed [PHASE_WIDTH-1:0] phase_reg;
    logic signed [23:0]            integ_reg;
    logic signed [39:0]            lc_reg;
    logic        [1:0]             prev_sign_reg;
    logic        [1:0]             sign_hist_reg  [HIST_D];
    logic signed [23:0]            integ_hist_reg [HIST_D];
    logic        [31:0]            rev_reg;
    logic        [63:0]            sqsum_reg;

    // working registers
    logic signed [31:0] noise_reg;
    logic        [39:0] lmag_reg;
    logic               lneg_reg;
    logic        [31:0] rnd_reg;
    logic        [41:0] pmag_reg;
    logic               pneg_reg;
    logic        [63:0] plo_reg;
    logic signed [63:0] term_reg;
    logic signed [63:0] acc_reg;
    logic        [31:0] absd_reg;
    logic               big_reg;
    logic               out_valid_reg;

    logic [bbpll_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [bbpll_pkg::PROD_W-1:0] prod;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
        logic signed [64:0] s;
        s = 65'(x) + 65'(y);
        if (s[64] != s[63])
            return s[64] ? bbpll_pkg::S64_MIN : bbpll_pkg::S64_MAX;
        return s[63:0];
    endfunction

    bbpll_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    logic in_fire, out_free;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // delayed loop filter inputs
    logic        [1:0]  sign_d;
    logic signed [23:0] integ_d;
    logic        [23:0] imag;
    assign sign_d  = sign_hist_reg[LOOP_DELAY];
    assign integ_d = integ_hist_reg[LOOP_DELAY];
    assign imag    = integ_d[23] ? 24'(-integ_d) : 24'(integ_d);

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MLO:
            begin
                mul_a = dco_gain_reg;
                mul_b = lmag_reg[31:0];
            end
            ST_MHI:
            begin
                mul_a = dco_gain_reg;
                mul_b = 32'(lmag_reg[39:32]);
            end
            ST_DLO:
            begin
                mul_a = 32'(divide_reg);
                mul_b = pmag_reg[31:0];
            end
            ST_DHI:
            begin
                mul_a = 32'(divide_reg);
                mul_b = 32'(pmag_reg[41:32]);
            end
            ST_SQ:
            begin
                mul_a = absd_reg;
                mul_b = absd_reg;
            end
            // held while the result waits so the control product stays valid
            ST_CTL, ST_OUT:
            begin
                mul_a = 32'(int_gain_reg);
                mul_b = 32'(imag);
            end
            default:
            begin
            end
        endcase
    end

    // dco period from the adjustment products
    logic        [40:0] adj_mag;
    logic signed [41:0] adj;
    logic signed [42:0] period;
    assign adj_mag = 41'(prod[39:0]) + 41'(rnd_reg);
    assign adj     = lneg_reg ? -$signed({1'b0, adj_mag}) : $signed({1'b0, adj_mag});
    assign period  = $signed(43'(free_period_reg)) + 43'(adj);

    // divider product, negated in the sum step so that it subtracts
    logic [63:0] dprod;
    assign dprod = plo_reg + {prod[31:0], 32'b0};

    // phase error and detector
    logic signed [63:0] errc;
    logic        [1:0]  sign_cur;
    logic signed [23:0] integ_new;
    logic        [63:0] absd;
    logic               reversal;
    always_comb
    begin
        if (acc_reg > PH_MAX)
            errc = PH_MAX;
        else if (acc_reg < PH_MIN)
            errc = PH_MIN;
        else
            errc = acc_reg;

        if (errc > 64'sd0)
            sign_cur = bbpll_pkg::SIGN_POS;
        else if (errc < 64'sd0)
            sign_cur = bbpll_pkg::SIGN_NEG;
        else
            sign_cur = bbpll_pkg::SIGN_ZERO;

        integ_new = integ_reg;
        if (sign_cur == bbpll_pkg::SIGN_POS && integ_reg != bbpll_pkg::INTEG_MAX)
            integ_new = integ_reg + 24'sd1;
        else if (sign_cur == bbpll_pkg::SIGN_NEG && integ_reg != bbpll_pkg::INTEG_MIN)
            integ_new = integ_reg - 24'sd1;

        absd = errc[63] ? (64'd0 - 64'(errc)) : 64'(errc);
        reversal = (sign_cur == bbpll_pkg::SIGN_POS && prev_sign_reg == bbpll_pkg::SIGN_NEG)
                || (sign_cur == bbpll_pkg::SIGN_NEG && prev_sign_reg == bbpll_pkg::SIGN_POS);
    end

    // square sum and control word
    logic        [64:0] sq_add;
    logic signed [41:0] ip;
    logic signed [17:0] pp;
    logic signed [42:0] ctrl;
    logic signed [42:0] ctrl_sat;
    always_comb
    begin
        sq_add = {1'b0, sqsum_reg} + {1'b0, prod};
        ip = integ_d[23] ? -$signed({1'b0, prod[40:0]}) : $signed({1'b0, prod[40:0]});
        unique case (sign_d)
            bbpll_pkg::SIGN_POS: pp = $signed({1'b0, prop_gain_reg});
            bbpll_pkg::SIGN_NEG: pp = -$signed({1'b0, prop_gain_reg});
            default:             pp = 18'sd0;
        endcase
        ctrl = 43'(ip) + 43'(pp);
        if (ctrl > bbpll_pkg::CTRL_MAX)
            ctrl_sat = bbpll_pkg::CTRL_MAX;
        else if (ctrl < bbpll_pkg::CTRL_MIN)
            ctrl_sat = bbpll_pkg::CTRL_MIN;
        else
            ctrl_sat = ctrl;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_MLO;
            ST_MLO:  state_next = ST_MHI;
            ST_MHI:  state_next = ST_PER;
            ST_PER:  state_next = ST_DLO;
            ST_DLO:  state_next = ST_DHI;
            ST_DHI:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_SUBP;
            ST_SUBP: state_next = ST_NOIS;
            ST_NOIS: state_next = ST_ERR;
            ST_ERR:  state_next = ST_SQ;
            ST_SQ:   state_next = ST_CTL;
            ST_CTL:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_period_reg  <= 32'd40000000;
            free_period_reg <= 32'd3999840;
            divide_reg      <= 10'd10;
            dco_gain_reg    <= 32'd1048576;
            prop_gain_reg   <= 17'd6554;
            int_gain_reg    <= 17'd655;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bbpll_pkg::REG_REF_PERIOD:  ref_period_reg  <= cfg_data;
                bbpll_pkg::REG_FREE_PERIOD: free_period_reg <= cfg_data;
                bbpll_pkg::REG_DIVIDE:      divide_reg      <= cfg_data[9:0];
                bbpll_pkg::REG_DCO_GAIN:    dco_gain_reg    <= cfg_data;
                bbpll_pkg::REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[16:0];
                bbpll_pkg::REG_INT_GAIN:    int_gain_reg    <= cfg_data[16:0];
                default:
                begin
                end
            endcase
        end
    end

    // loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            integ_reg     <= '0;
            lc_reg        <= '0;
            prev_sign_reg <= bbpll_pkg::SIGN_ZERO;
            rev_reg       <= '0;
            sqsum_reg     <= '0;
            for (int i = 0; i < HIST_D; i++)
            begin
                sign_hist_reg[i]  <= bbpll_pkg::SIGN_ZERO;
                integ_hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_fire && restart)
            begin
                phase_reg     <= '0;
                integ_reg     <= '0;
                lc_reg        <= '0;
                prev_sign_reg <= bbpll_pkg::SIGN_ZERO;
                rev_reg       <= '0;
                sqsum_reg     <= '0;
                for (int i = 0; i < HIST_D; i++)
                begin
                    sign_hist_reg[i]  <= bbpll_pkg::SIGN_ZERO;
                    integ_hist_reg[i] <= '0;
                end
            end
            if (state_reg == ST_ERR)
            begin
                phase_reg     <= errc[PHASE_WIDTH-1:0];
                integ_reg     <= integ_new;
                prev_sign_reg <= sign_cur;
                if (reversal && rev_reg != 32'hffff_ffff)
                    rev_reg <= rev_reg + 32'd1;
                for (int i = LOOP_DELAY; i > 0; i--)
                begin
                    sign_hist_reg[i]  <= sign_hist_reg[i-1];
                    integ_hist_reg[i] <= integ_hist_reg[i-1];
                end
                sign_hist_reg[0]  <= sign_cur;
                integ_hist_reg[0] <= integ_new;
            end
            if (state_reg == ST_CTL)
            begin
                if (big_reg || sq_add[64])
                    sqsum_reg <= 64'hffff_ffff_ffff_ffff;
                else
                    sqsum_reg <= sq_add[63:0];
            end
            if (state_reg == ST_OUT && out_free)
                lc_reg <= ctrl_sat[39:0];
        end
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            noise_reg <= noise_fs;
            // magnitude of the loop control that this step starts from
            if (restart)
            begin
                lmag_reg <= '0;
                lneg_reg <= 1'b0;
            end
            else
            begin
                lmag_reg <= lc_reg[39] ? 40'(-lc_reg) : 40'(lc_reg);
                lneg_reg <= lc_reg[39];
            end
        end
        unique case (state_reg)
            ST_MLO:  acc_reg  <= sat_add(64'(phase_reg), $signed(64'(ref_period_reg)));
            ST_MHI:  rnd_reg  <= 32'((prod + 64'h8000_0000) >> 32);
            ST_PER:
            begin
                pmag_reg <= period[42] ? 42'(-period) : 42'(period);
                pneg_reg <= period[42];
            end
            ST_DHI:  plo_reg  <= prod;
            ST_SUM:  term_reg <= pneg_reg ? $signed(dprod) : $signed(64'd0 - dprod);
            ST_SUBP: acc_reg  <= sat_add(acc_reg, term_reg);
            ST_NOIS: acc_reg  <= sat_add(acc_reg, 64'sd0 - 64'(noise_reg));
            ST_ERR:
            begin
                absd_reg <= absd[31:0];
                big_reg  <= |absd[63:32];
            end
            default:
            begin
            end
        endcase
    end

    // result register
    logic signed [63:0] phase_ext;
    assign phase_ext = 64'(phase_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            phase_err_fs   <= phase_ext[47:0];
            detector_sign  <= prev_sign_reg;
            control_word   <= ctrl_sat[39:0];
            reversal_count <= rev_reg;
            square_sum     <= sqsum_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
